// File: rtl/core/bms_pkg.sv
// ----------------------------------------------------------------------------
// bms_pkg: shared types and constants for box_merge_and_sort
// Register indexes and the controller-to-datapath command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none
package bms_pkg;
    localparam int CFG_BITS = 4;
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_VERT   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAP    = 2'd2;
    localparam logic [CFG_BITS-1:0] RST_HEIGHT = 4'd2;
    localparam logic [CFG_BITS-1:0] RST_VERT   = 4'd2;
    localparam logic [CFG_BITS-1:0] RST_GAP    = 4'd6;

    // datapath operation codes
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,   // write input box at count
        OP_RDI,    // read entry i into holding register A
        OP_RDJ,    // read entry j into holding register B
        OP_MERGE,  // write union of A,B to entry i
        OP_SHIFT,  // copy read data (entry k+1 or k-1) to entry k (two steps: read, write)
        OP_WRB,    // write B to entry k
        OP_RDOUT   // read entry k to output register
    } t_op;

    typedef struct packed {
        t_op op;
        logic [6:0] addr;   // wide enough for any MAX_BOXES up to 128
    } t_cmd;

    typedef struct packed {
        logic alike;
        logic b_less;       // left of held B below left at read data
    } t_stat;
endpackage
`default_nettype wire

// File: rtl/core/bms_box_if.sv
// ----------------------------------------------------------------------------
// bms_box_if: valid/ready channel carrying one box
// Used for both input and result channels.
// ----------------------------------------------------------------------------
`default_nettype none
interface bms_box_if #(parameter int COORD_BITS = 10);
    logic valid;
    logic ready;
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] top;
    logic [COORD_BITS:0]   width;
    logic [COORD_BITS:0]   height;
    logic                  last;
    logic                  overflow;
    modport source(output valid, left, top, width, height, last, overflow, input ready);
    modport sink(input valid, left, top, width, height, last, overflow, output ready);
endinterface
`default_nettype wire

// File: rtl/core/box_merge_and_sort.sv
// ----------------------------------------------------------------------------
// box_merge_and_sort: collect boxes, merge alike pairs, emit sorted by left
//
// Input channel i_box: one box per transfer, final flag ends the set. Up to
// MAX_BOXES are stored; more are dropped and flagged on every result.
// After the final box the block stops taking input, runs a pairwise merge
// scan (later entries move down when a box is removed) and an insertion sort,
// all through one single-port store with registered read. This store port
// sets the pace: the run time grows quadratically with the box count.
// Loading takes one box per cycle.
// Results leave on o_box, one transfer per surviving box, ascending left,
// last flag on the final one; the next result is fetched after each is taken.
// A stalled receiver simply holds the result; nothing is lost.
// Reset (synchronous, active low) empties the set and restores the limit
// registers to 2 and 2 quarters and 6 eighths. Configure only while idle.
// ----------------------------------------------------------------------------
`default_nettype none
module box_merge_and_sort #(
    parameter int MAX_BOXES  = 32,
    parameter int COORD_BITS = 10
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bms_box_if.sink   i_box,
    bms_box_if.source o_box,
    input  wire logic i_cfg_we,
    input  wire logic [bms_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [bms_pkg::CFG_BITS-1:0]     i_cfg_data
);
    logic [bms_pkg::CFG_BITS-1:0] r_hq, r_vq, r_gq;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hq <= bms_pkg::RST_HEIGHT;
            r_vq <= bms_pkg::RST_VERT;
            r_gq <= bms_pkg::RST_GAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bms_pkg::REG_HEIGHT: r_hq <= i_cfg_data;
                bms_pkg::REG_VERT:   r_vq <= i_cfg_data;
                bms_pkg::REG_GAP:    r_gq <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bms_pkg::t_cmd  w_cmd;
    bms_pkg::t_stat w_stat;

    bms_ctrl #(.MAX_BOXES(MAX_BOXES)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(i_box.valid), .i_in_final(i_box.last), .o_in_ready(i_box.ready),
        .o_out_valid(o_box.valid), .o_out_last(o_box.last), .o_out_ovf(o_box.overflow),
        .i_out_ready(o_box.ready), .i_stat(w_stat), .o_cmd(w_cmd)
    );

    bms_datapath #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(COORD_BITS)) u_dp (
        .i_clk, .i_cmd(w_cmd),
        .i_left(i_box.left), .i_top(i_box.top),
        .i_width(i_box.width), .i_height(i_box.height),
        .i_hq(r_hq), .i_vq(r_vq), .i_gq(r_gq),
        .o_stat(w_stat),
        .o_left(o_box.left), .o_top(o_box.top),
        .o_width(o_box.width), .o_height(o_box.height)
    );
endmodule
`default_nettype wire

// File: rtl/core/bms_datapath.sv
// ----------------------------------------------------------------------------
// bms_datapath: box store, holding registers and pair compare
// Single-port store with registered read; A and B hold boxes under test.
// ----------------------------------------------------------------------------
`default_nettype none
module bms_datapath #(
    parameter int MAX_BOXES  = 32,
    parameter int COORD_BITS = 10
) (
    input  wire logic i_clk,
    input  wire bms_pkg::t_cmd i_cmd,
    input  wire logic [COORD_BITS-1:0] i_left,
    input  wire logic [COORD_BITS-1:0] i_top,
    input  wire logic [COORD_BITS:0]   i_width,
    input  wire logic [COORD_BITS:0]   i_height,
    input  wire logic [bms_pkg::CFG_BITS-1:0] i_hq,
    input  wire logic [bms_pkg::CFG_BITS-1:0] i_vq,
    input  wire logic [bms_pkg::CFG_BITS-1:0] i_gq,
    output bms_pkg::t_stat o_stat,
    output logic [COORD_BITS-1:0] o_left,
    output logic [COORD_BITS-1:0] o_top,
    output logic [COORD_BITS:0]   o_width,
    output logic [COORD_BITS:0]   o_height
);
    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int PW = COORD_BITS;
    localparam int SW = COORD_BITS + 1;
    localparam int EW = 2*PW + 2*SW;
    localparam logic [SW+1:0] SMAX = {2'b00, {SW{1'b1}}};

    logic [EW-1:0] r_mem [MAX_BOXES];
    logic [EW-1:0] r_rd;      // registered read data
    logic [EW-1:0] r_a;
    logic [EW-1:0] r_b;
    logic [EW-1:0] r_out;
    logic r_alike;
    logic [EW-1:0] n_union;
    logic [AW-1:0] w_addr;

    assign w_addr = i_cmd.addr[AW-1:0];

    // field views
    logic [PW-1:0] al, at, bl, bt;
    logic [SW-1:0] aw, ah, bw, bh;
    assign {al, at, aw, ah} = r_a;
    assign {bl, bt, bw, bh} = r_b;

    // pair test on A (first) and B (second)
    logic [SW-1:0] hd;
    logic [PW-1:0] vd;
    logic signed [SW+1:0] gap;
    logic [SW+1:0] gabs;
    logic [SW+1:0] wsum;
    logic alike;
    always_comb begin
        hd = (ah > bh) ? ah - bh : bh - ah;
        vd = (at > bt) ? at - bt : bt - at;
        if (al < bl)
            gap = $signed({2'b00, bl}) - $signed({2'b00, al}) - $signed({1'b0, aw});
        else
            gap = $signed({2'b00, al}) - $signed({2'b00, bl}) - $signed({1'b0, bw});
        gabs = gap[SW+1] ? (SW+2)'(-gap) : (SW+2)'(gap);
        wsum = {2'b00, aw} + {2'b00, bw};
        alike = ({2'b00, hd, 2'b00} < ({{SW{1'b0}}, i_hq} * {4'b0000, ah}))
             && ({3'b000, vd, 2'b00} < ({{SW{1'b0}}, i_vq} * {4'b0000, ah}))
             && ({gabs, 3'b000} < ({{(SW+1){1'b0}}, i_gq} * {3'b000, wsum}));
    end

    // union of A and B
    logic [PW-1:0] ux, uy;
    logic [SW+1:0] ra, rb, ba, bb, uw, uh;
    always_comb begin
        ux = (al < bl) ? al : bl;
        uy = (at < bt) ? at : bt;
        ra = {2'b00, al} + {1'b0, aw};
        rb = {2'b00, bl} + {1'b0, bw};
        ba = {2'b00, at} + {1'b0, ah};
        bb = {2'b00, bt} + {1'b0, bh};
        uw = ((ra > rb) ? ra : rb) - {2'b00, ux};
        uh = ((ba > bb) ? ba : bb) - {2'b00, uy};
        if (uw > SMAX) uw = SMAX;
        if (uh > SMAX) uh = SMAX;
        n_union = {ux, uy, uw[SW-1:0], uh[SW-1:0]};
    end

    logic [PW-1:0] rdl;
    assign rdl = r_rd[EW-1 -: PW];

    always_ff @(posedge i_clk) begin
        r_alike <= alike;
        unique case (i_cmd.op)
            bms_pkg::OP_LOAD:  r_mem[w_addr] <= {i_left, i_top, i_width, i_height};
            bms_pkg::OP_MERGE: r_mem[w_addr] <= n_union;
            bms_pkg::OP_SHIFT: r_mem[w_addr] <= r_rd;
            bms_pkg::OP_WRB:   r_mem[w_addr] <= r_b;
            default: r_rd <= r_mem[w_addr];
        endcase
        if (i_cmd.op == bms_pkg::OP_RDI) r_a <= r_mem[w_addr];
        if (i_cmd.op == bms_pkg::OP_RDJ) r_b <= r_mem[w_addr];
        if (i_cmd.op == bms_pkg::OP_MERGE) r_a <= n_union;
        if (i_cmd.op == bms_pkg::OP_RDOUT) r_out <= r_mem[w_addr];
    end

    // sort compare is live on held B and the current read data
    assign o_stat = '{alike: r_alike, b_less: (bl < rdl)};
    assign {o_left, o_top, o_width, o_height} = r_out;
endmodule
`default_nettype wire

// File: rtl/core/bms_ctrl.sv
// ----------------------------------------------------------------------------
// bms_ctrl: sequencer for load, merge scan, insertion sort and output
// Issues one store access a cycle to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module bms_ctrl #(
    parameter int MAX_BOXES = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_final,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output logic      o_out_last,
    output logic      o_out_ovf,
    input  wire logic i_out_ready,
    input  wire bms_pkg::t_stat i_stat,
    output bms_pkg::t_cmd o_cmd
);
    localparam int CW = $clog2(MAX_BOXES + 1);
    typedef enum logic [3:0] {
        S_LOAD, S_MI, S_MJ, S_MT, S_MDEC, S_SH_RD, S_SH_WR,
        S_SI, S_SR, S_SW, S_SCMP, S_SPUT, S_ORD, S_OUT
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_cnt, r_i, r_j, r_k;
    logic r_ovf;

    assign o_in_ready = (r_state == S_LOAD);
    logic acc;
    assign acc = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd = '{op: bms_pkg::OP_NONE, addr: '0};
        unique case (r_state)
            S_LOAD: if (acc && r_cnt < CW'(MAX_BOXES))
                o_cmd = '{op: bms_pkg::OP_LOAD, addr: 7'(r_cnt)};
            S_MI:   o_cmd = '{op: bms_pkg::OP_RDI, addr: 7'(r_i)};
            S_MJ:   o_cmd = '{op: bms_pkg::OP_RDJ, addr: 7'(r_j)};
            S_MDEC: if (i_stat.alike)
                o_cmd = '{op: bms_pkg::OP_MERGE, addr: 7'(r_i)};
            S_SH_RD: o_cmd = '{op: bms_pkg::OP_NONE, addr: 7'(r_k + 1'b1)};
            S_SH_WR: o_cmd = '{op: bms_pkg::OP_SHIFT, addr: 7'(r_k)};
            S_SI:   o_cmd = '{op: bms_pkg::OP_RDJ, addr: 7'(r_i)};
            S_SR:   o_cmd = '{op: bms_pkg::OP_NONE, addr: 7'(r_k - 1'b1)};
            // keep read data on entry k-1 for the compare and the move
            S_SCMP: o_cmd = '{op: bms_pkg::OP_NONE, addr: 7'(r_k - 1'b1)};
            S_SW:   o_cmd = '{op: bms_pkg::OP_SHIFT, addr: 7'(r_k)};
            S_SPUT: o_cmd = '{op: bms_pkg::OP_WRB, addr: 7'(r_k)};
            S_ORD:  o_cmd = '{op: bms_pkg::OP_RDOUT, addr: 7'(r_k)};
            default: o_cmd = '{op: bms_pkg::OP_NONE, addr: '0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt <= '0;
            r_ovf <= 1'b0;
            r_i <= '0; r_j <= '0; r_k <= '0;
            o_out_valid <= 1'b0;
            o_out_last <= 1'b0;
            o_out_ovf <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: if (acc) begin
                    logic [CW-1:0] nc;
                    nc = (r_cnt < CW'(MAX_BOXES)) ? r_cnt + 1'b1 : r_cnt;
                    r_cnt <= nc;
                    if (r_cnt >= CW'(MAX_BOXES)) r_ovf <= 1'b1;
                    if (i_in_final) begin
                        r_i <= '0;
                        r_state <= S_MI;
                    end
                end
                S_MI: begin
                    if (r_i + 1'b1 >= r_cnt) begin
                        r_i <= CW'(1);
                        r_state <= S_SI;
                    end else begin
                        r_j <= r_i + 1'b1;
                        r_state <= S_MJ;
                    end
                end
                S_MJ: r_state <= S_MT;
                S_MT: r_state <= S_MDEC;
                S_MDEC: begin
                    if (i_stat.alike) begin
                        r_k <= r_j;
                        if (r_j + 1'b1 < r_cnt) r_state <= S_SH_RD;
                        else begin
                            r_cnt <= r_cnt - 1'b1;
                            r_j <= r_i + 1'b1;
                            r_state <= (r_i + 1'b1 < r_cnt - 1'b1) ? S_MJ : S_MI;
                            if (!(r_i + 1'b1 < r_cnt - 1'b1)) r_i <= r_i + 1'b1;
                        end
                    end else if (r_j + 1'b1 < r_cnt) begin
                        r_j <= r_j + 1'b1;
                        r_state <= S_MJ;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_MI;
                    end
                end
                S_SH_RD: r_state <= S_SH_WR;
                S_SH_WR: begin
                    if (r_k + 2'd2 < r_cnt) begin
                        r_k <= r_k + 1'b1;
                        r_state <= S_SH_RD;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                        r_j <= r_i + 1'b1;
                        if (r_i + 1'b1 < r_cnt - 1'b1) r_state <= S_MJ;
                        else begin
                            r_i <= r_i + 1'b1;
                            r_state <= S_MI;
                        end
                    end
                end
                S_SI: begin
                    if (r_i >= r_cnt) begin
                        r_k <= '0;
                        r_state <= (r_cnt == '0) ? S_LOAD : S_ORD;
                        if (r_cnt == '0) r_ovf <= 1'b0;
                    end else begin
                        r_k <= r_i;
                        r_state <= S_SR;
                    end
                end
                S_SR: r_state <= S_SCMP;
                S_SCMP: begin
                    if (i_stat.b_less) r_state <= S_SW;
                    else r_state <= S_SPUT;
                end
                S_SW: begin
                    if (r_k == CW'(1)) begin
                        r_k <= '0;
                        r_state <= S_SPUT;
                    end else begin
                        r_k <= r_k - 1'b1;
                        r_state <= S_SR;
                    end
                end
                S_SPUT: begin
                    r_i <= r_i + 1'b1;
                    r_state <= S_SI;
                end
                S_ORD: r_state <= S_OUT;
                S_OUT: begin
                    if (!o_out_valid) begin
                        o_out_valid <= 1'b1;
                        o_out_last <= (r_k + 1'b1 == r_cnt);
                        o_out_ovf <= r_ovf;
                    end else if (i_out_ready) begin
                        o_out_valid <= 1'b0;
                        if (o_out_last) begin
                            r_cnt <= '0;
                            r_ovf <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_k <= r_k + 1'b1;
                            r_state <= S_ORD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for box_merge_and_sort
// Sends sets of boxes, predicts the merged and sorted result sets, and checks
// every result transfer field by field while both channels idle at random in most phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
    localparam int NBOX  = 32;
    localparam int SZMAX = 2047;
    localparam int LIMIT = 4000000;
    localparam int CB    = bms_pkg::CFG_BITS;
    localparam logic [bms_pkg::CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [9:0]  left;
        logic [9:0]  top;
        logic [10:0] width;
        logic [10:0] height;
        logic        last;
        logic        ovf;
    } t_box;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [bms_pkg::CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [bms_pkg::CFG_BITS-1:0] i_cfg_data = '0;

    bms_box_if #(.COORD_BITS(10)) in_if ();
    bms_box_if #(.COORD_BITS(10)) out_if ();

    box_merge_and_sort dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_box(in_if.sink), .o_box(out_if.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state: a mirror of the block's box store and limits.
    int lim_h, lim_v, lim_g;
    int s_l[NBOX], s_t[NBOX], s_w[NBOX], s_h[NBOX];
    int n_stored;
    bit dropped;
    t_box expected_boxes[$];

    int errors = 0;
    int cycles = 0;
    bit long_hold = 0;
    bit rx_quiet = 0;

    initial begin
        in_if.valid = 1'b0;
        in_if.left = '0;
        in_if.top = '0;
        in_if.width = '0;
        in_if.height = '0;
        in_if.last = 1'b0;
        in_if.overflow = 1'b0;
        out_if.ready = 1'b0;
    end

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic int iabs(input int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit pair_alike(input int i, input int j);
        int gap;
        gap = s_l[i] < s_l[j] ? s_l[j] - (s_l[i] + s_w[i]) : s_l[i] - (s_l[j] + s_w[j]);
        return 4 * iabs(s_h[i] - s_h[j]) < lim_h * s_h[i]
            && 4 * iabs(s_t[i] - s_t[j]) < lim_v * s_h[i]
            && 8 * iabs(gap) < lim_g * (s_w[i] + s_w[j]);
    endfunction

    function automatic void drop_entry(input int j);
        for (int k = j; k + 1 < n_stored; k++) begin
            s_l[k] = s_l[k+1]; s_t[k] = s_t[k+1];
            s_w[k] = s_w[k+1]; s_h[k] = s_h[k+1];
        end
        n_stored--;
    endfunction

    // Union-merge scan, stable sort on left, then queue the result set.
    function automatic void merge_sort_emit();
        int j, x, y, w, h, l, t, ww, hh, k;
        t_box b;
        for (int i = 0; i < n_stored; i++) begin
            j = i + 1;
            while (j < n_stored) begin
                if (pair_alike(i, j)) begin
                    x = s_l[i] < s_l[j] ? s_l[i] : s_l[j];
                    y = s_t[i] < s_t[j] ? s_t[i] : s_t[j];
                    w = ((s_l[i] + s_w[i]) > (s_l[j] + s_w[j]) ?
                         (s_l[i] + s_w[i]) : (s_l[j] + s_w[j])) - x;
                    h = ((s_t[i] + s_h[i]) > (s_t[j] + s_h[j]) ?
                         (s_t[i] + s_h[i]) : (s_t[j] + s_h[j])) - y;
                    if (w > SZMAX) w = SZMAX;
                    if (h > SZMAX) h = SZMAX;
                    s_l[i] = x; s_t[i] = y; s_w[i] = w; s_h[i] = h;
                    drop_entry(j);
                    j = i + 1;
                end else begin
                    j++;
                end
            end
        end
        for (int i = 1; i < n_stored; i++) begin
            l = s_l[i]; t = s_t[i]; ww = s_w[i]; hh = s_h[i];
            k = i;
            while (k > 0 && s_l[k-1] > l) begin
                s_l[k] = s_l[k-1]; s_t[k] = s_t[k-1];
                s_w[k] = s_w[k-1]; s_h[k] = s_h[k-1];
                k--;
            end
            s_l[k] = l; s_t[k] = t; s_w[k] = ww; s_h[k] = hh;
        end
        for (int i = 0; i < n_stored; i++) begin
            b.left = 10'(s_l[i]); b.top = 10'(s_t[i]);
            b.width = 11'(s_w[i]); b.height = 11'(s_h[i]);
            b.last = (i == n_stored - 1);
            b.ovf = dropped;
            expected_boxes.insert(expected_boxes.size(), b);
        end
        n_stored = 0;
        dropped = 0;
    endfunction

    function automatic void predict_box(input t_box b);
        if (n_stored < NBOX) begin
            s_l[n_stored] = b.left; s_t[n_stored] = b.top;
            s_w[n_stored] = b.width; s_h[n_stored] = b.height;
            n_stored++;
        end else begin
            dropped = 1;
        end
        if (b.last) merge_sort_emit();
    endfunction

    // Sender burst state: a random gap (sometimes none), then a burst of random length.
    int burst_left = 0;

    task automatic send_box(input t_box b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_if.valid <= 1'b1;
        in_if.left <= b.left;
        in_if.top <= b.top;
        in_if.width <= b.width;
        in_if.height <= b.height;
        in_if.last <= b.last;
        do @(posedge i_clk); while (!in_if.ready);
        predict_box(b);
    endtask

    function automatic t_box make_box(input int l, input int t, input int w, input int h,
                                      input bit fin);
        t_box b;
        b.left = 10'(l); b.top = 10'(t); b.width = 11'(w); b.height = 11'(h);
        b.last = fin; b.ovf = 0;
        return b;
    endfunction

    // A random box; widths and heights mostly moderate so merges happen.
    function automatic t_box rand_box(input bit fin);
        int w, h;
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2047) : $urandom_range(1, 60);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2047) : $urandom_range(8, 60);
        return make_box($urandom_range(0, 1023), $urandom_range(0, 1023), w, h, fin);
    endfunction

    // Rows of near-alike boxes, so merge chains and restarts are exercised.
    function automatic t_box row_box(input int base_t, input int x, input bit fin);
        return make_box(x, base_t + $urandom_range(0, 4), $urandom_range(8, 20),
                        $urandom_range(28, 32), fin);
    endfunction

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (expected_boxes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_limits(input int h, input int v, input int g);
        wait_drained();
        i_cfg_we <= 1'b1; i_cfg_idx <= bms_pkg::REG_HEIGHT; i_cfg_data <= CB'(h);
        @(posedge i_clk);
        i_cfg_idx <= bms_pkg::REG_VERT; i_cfg_data <= CB'(v);
        @(posedge i_clk);
        i_cfg_idx <= bms_pkg::REG_GAP; i_cfg_data <= CB'(g);
        @(posedge i_clk);
        // the spare index selects no register and must be ignored
        i_cfg_idx <= REG_SPARE; i_cfg_data <= CB'($urandom_range(0, 15));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        lim_h = h; lim_v = v; lim_g = g;
    endtask

    // Extremes of the fields, a merge pair, a tie in left and a lone final box.
    task automatic test_directed();
        send_box(make_box(0, 0, 1, 1, 0));
        send_box(make_box(1023, 1023, 1024, 1024, 0));
        send_box(make_box(1023, 1023, 1024, 1024, 0));
        send_box(make_box(500, 100, 20, 40, 0));
        send_box(make_box(525, 102, 20, 40, 0));
        send_box(make_box(500, 300, 10, 10, 0));
        send_box(make_box(100, 200, 2047, 2047, 1));
        send_box(make_box(1023, 0, 2047, 1, 1));
        send_box(make_box(10, 10, 20, 40, 0));
        send_box(make_box(10, 10, 20, 40, 1));
    endtask

    // More than the store holds; the final box itself is dropped.
    task automatic test_overflow();
        for (int k = 0; k < 34; k++) send_box(rand_box(k == 33));
        for (int k = 0; k < 33; k++) send_box(row_box(50, 30 * k, k == 32));
    endtask

    task automatic test_random_sets(input int sets);
        int n, base, x;
        for (int s = 0; s < sets; s++) begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 8);
            base = $urandom_range(0, 900);
            x = $urandom_range(0, 400);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 3) != 0) begin
                    send_box(row_box(base, x, k == n - 1));
                    x = (x + $urandom_range(15, 40)) % 1024;
                end else begin
                    send_box(rand_box(k == n - 1));
                end
            end
        end
    endtask

    // The receiver holds off while sets keep arriving, so the input stalls.
    task automatic test_backpressure();
        long_hold = 1;
        test_random_sets(4);
        long_hold = 0;
        wait_drained();
    endtask

    // Receiver: random stall pattern, always ready when quiet, or a long counted hold-off.
    always @(posedge i_clk) begin
        int hold;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (long_hold) begin
            out_if.ready <= 1'b0;
            for (hold = 0; hold < 300; hold++) @(posedge i_clk);
            out_if.ready <= 1'b1;
        end else if (rx_quiet) begin
            out_if.ready <= 1'b1;
        end else begin
            out_if.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Checker: each result transfer against the oldest expected box.
    always @(posedge i_clk) begin
        t_box e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_boxes.size() == 0) begin
                report("unexpected result left", out_if.left, 0);
            end else begin
                e = expected_boxes.pop_front();
                if (out_if.left != e.left) report("left", out_if.left, e.left);
                if (out_if.top != e.top) report("top", out_if.top, e.top);
                if (out_if.width != e.width) report("width", out_if.width, e.width);
                if (out_if.height != e.height) report("height", out_if.height, e.height);
                if (out_if.last != e.last) report("last", out_if.last, e.last);
                if (out_if.overflow != e.ovf) report("overflow", out_if.overflow, e.ovf);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        lim_h = bms_pkg::RST_HEIGHT; lim_v = bms_pkg::RST_VERT; lim_g = bms_pkg::RST_GAP;
        n_stored = 0;
        dropped = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_overflow();
        test_random_sets(12);
        test_backpressure();
        write_limits(15, 15, 15);
        test_random_sets(15);
        write_limits(0, 0, 0);
        test_random_sets(8);
        write_limits(4, 3, 10);
        rx_quiet = 1;
        test_random_sets(8);
        rx_quiet = 0;
        write_limits($urandom_range(1, 14), $urandom_range(1, 14), $urandom_range(1, 14));
        test_random_sets(10);
        // sender pauses until every result has arrived
        wait_drained();
        write_limits(bms_pkg::RST_HEIGHT, bms_pkg::RST_VERT, bms_pkg::RST_GAP);
        test_random_sets(10);

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && expected_boxes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// File: box_merge_and_sort.f
rtl/core/bms_pkg.sv
rtl/core/bms_box_if.sv
rtl/core/bms_datapath.sv
rtl/core/bms_ctrl.sv
rtl/core/box_merge_and_sort.sv
tb/tb_top.sv
